>>> rtl/dms3_pkg.sv
// ----------------------------------------------------------------------------
// dms3_pkg
// shared widths, register codes and tap selection type for the 3x3 depth
// mixture smoother
// ----------------------------------------------------------------------------
package dms3_pkg;

  localparam int DEPTH_W    = 16;
  localparam int MEAN_W     = 24;
  localparam int VAR_W      = 40;
  localparam int POS_W      = 10;
  localparam int COEF_W     = 16;
  localparam int DIM_CFG_W  = 11;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MARGIN_DEF     = 5;

  // weighted sums over one window (total weight 16)
  localparam int SUM_S_W = 5;
  localparam int SUM_A_W = 20;
  localparam int TERM_W  = 49;
  localparam int SUM_B_W = 53;

  // shared divider
  localparam int NUM_W = 58;
  localparam int DEN_W = 17;

  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_SENSOR_COEF  = 2'd2,
    CFG_BLANK_MARGIN = 2'd3
  } cfg_idx_e;

  // window row and column picked for each tap row / tap column
  typedef struct packed {
    logic [2:0][1:0] rsel;
    logic [2:0][1:0] csel;
  } tap_sel_t;

endpackage

>>> rtl/dms3_if.sv
// ----------------------------------------------------------------------------
// dms3 channels
// valid/ready channels for pixel items in and smoothed items out
// ----------------------------------------------------------------------------
interface dms3_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [dms3_pkg::DEPTH_W-1:0] depth;

  modport source (output valid, output opcode, output depth, input ready);
  modport sink   (input valid, input opcode, input depth, output ready);
endinterface

interface dms3_out_if;
  logic                        valid;
  logic                        ready;
  logic [dms3_pkg::MEAN_W-1:0] mean_depth;
  logic [dms3_pkg::VAR_W-1:0]  depth_variance;
  logic [dms3_pkg::POS_W-1:0]  pixel_row;
  logic [dms3_pkg::POS_W-1:0]  pixel_col;
  logic                        frame_end;

  modport source (output valid, output mean_depth, output depth_variance,
                  output pixel_row, output pixel_col, output frame_end, input ready);
  modport sink   (input valid, input mean_depth, input depth_variance,
                  input pixel_row, input pixel_col, input frame_end, output ready);
endinterface

>>> rtl/dms3_lbuf.sv
// ----------------------------------------------------------------------------
// dms3_lbuf
// two line stores, one read and one write port each, registered read
// ----------------------------------------------------------------------------
module dms3_lbuf #(
  parameter int DEPTH  = dms3_pkg::MAX_WIDTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [ADDR_W-1:0]            rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [ADDR_W-1:0]            wr_addr_i,
  input  logic [dms3_pkg::DEPTH_W-1:0] wr_a_i,
  input  logic [dms3_pkg::DEPTH_W-1:0] wr_b_i,
  output logic [dms3_pkg::DEPTH_W-1:0] rd_a_o,
  output logic [dms3_pkg::DEPTH_W-1:0] rd_b_o
);

  logic [dms3_pkg::DEPTH_W-1:0] mem_a [DEPTH];
  logic [dms3_pkg::DEPTH_W-1:0] mem_b [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_a[wr_addr_i] <= wr_a_i;
      mem_b[wr_addr_i] <= wr_b_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_o <= mem_a[rd_addr_i];
      rd_b_o <= mem_b[rd_addr_i];
    end
  end

endmodule

>>> rtl/dms3_acc.sv
// ----------------------------------------------------------------------------
// dms3_acc
// walks the nine window taps, forms the per-pixel term and accumulates the
// weighted count, depth sum and term sum
// ----------------------------------------------------------------------------
module dms3_acc (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [dms3_pkg::COEF_W-1:0]         coef_i,
  input  logic [2:0][2:0][dms3_pkg::DEPTH_W-1:0] win_i,
  input  dms3_pkg::tap_sel_t                  sel_i,
  output logic                                done_o,
  output logic [dms3_pkg::SUM_S_W-1:0]        sum_s_o,
  output logic [dms3_pkg::SUM_A_W-1:0]        sum_a_o,
  output logic [dms3_pkg::SUM_B_W-1:0]        sum_b_o
);

  logic       busy_q;
  logic [1:0] ky_q, kx_q;
  logic [dms3_pkg::DEPTH_W-1:0] tap;
  logic [1:0] sh;
  logic       last;

  logic v1_q, v2_q, v3_q, last1_q, last2_q, last3_q, done_q;
  logic [1:0] sh1_q, sh2_q, sh3_q;
  logic [dms3_pkg::DEPTH_W-1:0] d1_q, d2_q, d3_q;
  logic [31:0] dd1_q, dd2_q, dd3_q;
  logic [31:0] s2_q;
  logic [47:0] sv3_q;
  logic [dms3_pkg::TERM_W-1:0] term;

  logic [dms3_pkg::SUM_S_W-1:0] sum_s_q;
  logic [dms3_pkg::SUM_A_W-1:0] sum_a_q;
  logic [dms3_pkg::SUM_B_W-1:0] sum_b_q;

  // weight is 1, 2 or 4: a shift by the number of center coordinates
  assign tap  = win_i[sel_i.rsel[ky_q]][sel_i.csel[kx_q]];
  assign sh   = {1'b0, ky_q == 2'd1} + {1'b0, kx_q == 2'd1};
  assign last = (ky_q == 2'd2) && (kx_q == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ky_q   <= 2'd0;
      kx_q   <= 2'd0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        ky_q   <= 2'd0;
        kx_q   <= 2'd0;
      end else if (busy_q) begin
        if (kx_q == 2'd2) begin
          kx_q <= 2'd0;
          if (ky_q == 2'd2) busy_q <= 1'b0;
          else ky_q <= ky_q + 2'd1;
        end else begin
          kx_q <= kx_q + 2'd1;
        end
      end
      v1_q   <= busy_q && !start_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q && last3_q;
    end
  end

  // multiply chain: d*d, coef*d^2, s*s
  always_ff @(posedge clk_i) begin
    last1_q <= last;
    sh1_q   <= sh;
    d1_q    <= tap;
    dd1_q   <= 32'(tap) * 32'(tap);

    last2_q <= last1_q;
    sh2_q   <= sh1_q;
    d2_q    <= d1_q;
    dd2_q   <= dd1_q;
    s2_q    <= 32'((48'(coef_i) * 48'(dd1_q)) >> 16);

    last3_q <= last2_q;
    sh3_q   <= sh2_q;
    d3_q    <= d2_q;
    dd3_q   <= dd2_q;
    sv3_q   <= 48'((64'(s2_q) * 64'(s2_q)) >> 16);
  end

  assign term = {1'b0, dd3_q, 16'd0} + {1'b0, sv3_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_s_q <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
    end else if (v3_q && (d3_q != '0)) begin
      sum_s_q <= sum_s_q + (dms3_pkg::SUM_S_W'(1) << sh3_q);
      sum_a_q <= sum_a_q + (dms3_pkg::SUM_A_W'(d3_q) << sh3_q);
      sum_b_q <= sum_b_q + (dms3_pkg::SUM_B_W'(term) << sh3_q);
    end
  end

  assign done_o  = done_q;
  assign sum_s_o = sum_s_q;
  assign sum_a_o = sum_a_q;
  assign sum_b_o = sum_b_q;

endmodule

>>> rtl/dms3_div.sv
// ----------------------------------------------------------------------------
// dms3_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dms3_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dms3_pkg::NUM_W-1:0]  num_i,
  input  logic [dms3_pkg::DEN_W-1:0]  den_i,
  output logic                        done_o,
  output logic [dms3_pkg::NUM_W-1:0]  quo_o
);

  localparam int CNT_W = $clog2(dms3_pkg::NUM_W + 1);

  logic                       busy_q, done_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [dms3_pkg::NUM_W-1:0] num_q;
  logic [dms3_pkg::DEN_W:0]   rem_q;
  logic [dms3_pkg::DEN_W-1:0] den_q;
  logic [dms3_pkg::DEN_W:0]   rem_sh;
  logic                       fits;

  assign rem_sh = {rem_q[dms3_pkg::DEN_W-1:0], num_q[dms3_pkg::NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(dms3_pkg::NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      num_q <= {num_q[dms3_pkg::NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

>>> rtl/depth_mixture_smooth_3x3_core.sv
// ----------------------------------------------------------------------------
// depth_mixture_smooth_3x3_core
// 3x3 normalized-convolution smoother giving a mixture mean and variance
// ----------------------------------------------------------------------------
// usage
//   in_ch_i takes raw depth items in raster order (opcode 0) and, once the
//   frame is in, flush items (opcode 1) that drain the last row plus one
//   pixel. out_ch_o gives mean (Q16.8) and variance (Q32.8, saturating) for
//   each output pixel, with its row, column and a frame_end flag.
//   the configuration port writes width, height, noise coefficient and the
//   border blanking flag; a width or height write restarts the frame.
// item handling
//   one item is handled at a time. an item that makes no result goes through
//   a line store read, then write back and window shift. an item that makes
//   a result goes on to the nine-tap multiply and accumulate pass, the
//   products, and two passes of the shared 58-step divider (mean, then
//   variance), which dominates. a zero count skips both passes, a variance
//   that is not positive skips the second.
// reset
//   counters and window clear, registers take their defaults. the line stores
//   are not cleared; entries are always written before they reach a result.
// stalls
//   a finished result sits in the output register; the next item is taken
//   while it waits, and the block only holds when a new result is ready and
//   the old one is still not taken.
// ----------------------------------------------------------------------------
module depth_mixture_smooth_3x3_core #(
  parameter int MAX_WIDTH  = dms3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dms3_pkg::MAX_HEIGHT_DEF,
  parameter int MARGIN     = dms3_pkg::MARGIN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dms3_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dms3_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  dms3_in_if.sink                         in_ch_i,
  dms3_out_if.source                      out_ch_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);        // column index into the stores
  localparam int RIX_W = $clog2(MAX_HEIGHT);       // row of an output pixel
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);   // input row runs to height + 1

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_READ = 7'b0000010,
    ST_ACC  = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_DM   = 7'b0010000,
    ST_DV   = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  state_e state_q;

  // configuration
  logic [dms3_pkg::DIM_CFG_W-1:0] width_q, height_q;
  logic [dms3_pkg::COEF_W-1:0]    coef_q;
  logic                           blank_q;

  // stream position
  logic [ROW_W-1:0] in_row_q;
  logic [COL_W-1:0] in_col_q;

  // window [row: top, mid, bottom][col: oldest .. newest]
  logic [2:0][2:0][dms3_pkg::DEPTH_W-1:0] win_q;

  // item in flight
  logic [dms3_pkg::DEPTH_W-1:0] d_q;
  logic [COL_W-1:0]             addr_q;
  logic                         emit_q;
  logic                         acc_start_q;
  dms3_pkg::tap_sel_t           sel_q;
  logic [RIX_W-1:0]             emit_r_q;
  logic [COL_W-1:0]             emit_c_q;
  logic                         fend_q;

  // arithmetic
  logic [dms3_pkg::NUM_W-1:0]   p_q;
  logic [39:0]                  aa_q;
  logic [dms3_pkg::DEN_W-1:0]   den_q;
  logic [dms3_pkg::MEAN_W-1:0]  mean_q;
  logic [dms3_pkg::VAR_W-1:0]   var_q;

  // output register
  logic                         out_valid_q;
  logic [dms3_pkg::MEAN_W-1:0]  out_mean_q;
  logic [dms3_pkg::VAR_W-1:0]   out_var_q;
  logic [dms3_pkg::POS_W-1:0]   out_row_q, out_col_q;
  logic                         out_fend_q;

  // effective geometry, clamped to [3, MAX]
  logic [31:0] w32, h32, i32, j32, r32, c32;
  logic        in_fire, drain, tail, ignore, blank_px, pre_emit, post_emit, wrap;
  logic [dms3_pkg::DEPTH_W-1:0] pix_d;
  dms3_pkg::tap_sel_t           sel_d;

  always_comb begin
    if (width_q < 11'd3) w32 = 32'd3;
    else if (32'(width_q) > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    else w32 = 32'(width_q);
    if (height_q < 11'd3) h32 = 32'd3;
    else if (32'(height_q) > 32'(MAX_HEIGHT)) h32 = 32'(MAX_HEIGHT);
    else h32 = 32'(height_q);
  end

  assign in_ch_i.ready = (state_q == ST_IDLE);
  assign in_fire       = in_ch_i.valid && in_ch_i.ready;

  // decisions for the item at the port
  always_comb begin
    i32       = 32'(in_row_q);
    j32       = 32'(in_col_q);
    drain     = i32 >= h32;
    tail      = i32 > h32;
    ignore    = !drain && (in_ch_i.opcode == dms3_pkg::OP_FLUSH);
    blank_px  = blank_q && ((i32 < 32'(MARGIN)) || (i32 + 32'(MARGIN) >= h32) ||
                            (j32 < 32'(MARGIN)) || (j32 + 32'(MARGIN) >= w32));
    pix_d     = (drain || blank_px) ? '0 : in_ch_i.depth;
    pre_emit  = (j32 == 32'd0) && (i32 >= 32'd2);
    post_emit = (j32 >= 32'd1) && (i32 >= 32'd1);
    wrap      = j32 + 32'd1 >= w32;

    // position of the pixel that comes out
    if (tail) begin
      r32 = h32 - 32'd1;
      c32 = w32 - 32'd1;
    end else if (pre_emit) begin
      r32 = i32 - 32'd2;
      c32 = w32 - 32'd1;
    end else begin
      r32 = i32 - 32'd1;
      c32 = j32 - 32'd1;
    end

    // reflect-101 at the top and bottom rows
    sel_d.rsel[0] = (r32 == 32'd0) ? 2'd2 : 2'd0;
    sel_d.rsel[1] = 2'd1;
    sel_d.rsel[2] = (r32 + 32'd1 >= h32) ? 2'd0 : 2'd2;

    // columns: tail reads the unshifted window, the row-end case reads the
    // window after its shift (same pixels), otherwise the newest three
    if (tail) begin
      sel_d.csel = {2'd1, 2'd2, 2'd1};
    end else if (pre_emit) begin
      sel_d.csel = {2'd0, 2'd1, 2'd0};
    end else begin
      sel_d.csel[0] = (j32 == 32'd1) ? 2'd2 : 2'd0;
      sel_d.csel[1] = 2'd1;
      sel_d.csel[2] = 2'd2;
    end
  end

  // line stores
  logic                         mem_rd_en, mem_wr_en;
  logic [dms3_pkg::DEPTH_W-1:0] rd_top, rd_mid;

  assign mem_rd_en = (state_q == ST_IDLE) && in_fire && !ignore && !tail;
  assign mem_wr_en = (state_q == ST_READ);

  dms3_lbuf #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_lbuf (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (in_col_q),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (addr_q),
    .wr_a_i    (rd_mid),
    .wr_b_i    (d_q),
    .rd_a_o    (rd_top),
    .rd_b_o    (rd_mid)
  );

  // weighted sums over the window
  logic                          acc_done;
  logic [dms3_pkg::SUM_S_W-1:0]  sum_s;
  logic [dms3_pkg::SUM_A_W-1:0]  sum_a;
  logic [dms3_pkg::SUM_B_W-1:0]  sum_b;

  dms3_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc_start_q),
    .coef_i  (coef_q),
    .win_i   (win_q),
    .sel_i   (sel_q),
    .done_o  (acc_done),
    .sum_s_o (sum_s),
    .sum_a_o (sum_a),
    .sum_b_o (sum_b)
  );

  // shared divider: mean first, then variance
  logic                        div_start, div_done, var_pos;
  logic [dms3_pkg::NUM_W-1:0]  div_num, div_quo, mean_num, var_num, q_ext;
  logic [dms3_pkg::DEN_W-1:0]  div_den;

  assign mean_num = dms3_pkg::NUM_W'({sum_a, 8'd0}) + dms3_pkg::NUM_W'(sum_s >> 1);
  assign q_ext    = dms3_pkg::NUM_W'({aa_q, 16'd0});
  assign var_pos  = p_q > q_ext;
  assign var_num  = p_q - q_ext + dms3_pkg::NUM_W'(den_q >> 1);

  assign div_start = ((state_q == ST_MUL) && (sum_s != '0)) ||
                     ((state_q == ST_DM) && div_done && var_pos);
  assign div_num   = (state_q == ST_MUL) ? mean_num : var_num;
  assign div_den   = (state_q == ST_MUL) ? dms3_pkg::DEN_W'(sum_s) : den_q;

  dms3_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= 11'd640;
      height_q    <= 11'd480;
      coef_q      <= 16'd6120;
      blank_q     <= 1'b0;
      in_row_q    <= '0;
      in_col_q    <= '0;
      win_q       <= '0;
      emit_q      <= 1'b0;
      acc_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // tail item starts the window pass at once, other emitting items after the shift
      acc_start_q <= ((state_q == ST_IDLE) && in_fire && !ignore && tail) ||
                     ((state_q == ST_READ) && emit_q);

      if ((state_q == ST_OUT) && (!out_valid_q || out_ch_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.valid && out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && !ignore) begin
            if (tail) begin
              // final pixel of the frame, then back to the start
              in_row_q <= '0;
              in_col_q <= '0;
              state_q  <= ST_ACC;
            end else begin
              emit_q  <= pre_emit || post_emit;
              state_q <= ST_READ;
              if (wrap) begin
                in_col_q <= '0;
                in_row_q <= in_row_q + ROW_W'(1);
              end else begin
                in_col_q <= in_col_q + COL_W'(1);
              end
            end
          end
        end
        ST_READ: begin
          for (int y = 0; y < 3; y++) begin
            win_q[y][0] <= win_q[y][1];
            win_q[y][1] <= win_q[y][2];
          end
          win_q[0][2] <= rd_top;
          win_q[1][2] <= rd_mid;
          win_q[2][2] <= d_q;
          state_q <= emit_q ? ST_ACC : ST_IDLE;
        end
        ST_ACC: begin
          if (acc_done) state_q <= ST_MUL;
        end
        ST_MUL: begin
          // zero count gives zero mean and variance
          state_q <= (sum_s != '0) ? ST_DM : ST_OUT;
        end
        ST_DM: begin
          if (div_done) state_q <= var_pos ? ST_DV : ST_OUT;
        end
        ST_DV: begin
          if (div_done) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || out_ch_o.ready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase

      if (cfg_we_i) begin
        unique case (dms3_pkg::cfg_idx_e'(cfg_idx_i))
          dms3_pkg::CFG_IMAGE_WIDTH: begin
            width_q  <= cfg_wdata_i[dms3_pkg::DIM_CFG_W-1:0];
            in_row_q <= '0;
            in_col_q <= '0;
          end
          dms3_pkg::CFG_IMAGE_HEIGHT: begin
            height_q <= cfg_wdata_i[dms3_pkg::DIM_CFG_W-1:0];
            in_row_q <= '0;
            in_col_q <= '0;
          end
          dms3_pkg::CFG_SENSOR_COEF:  coef_q  <= cfg_wdata_i;
          dms3_pkg::CFG_BLANK_MARGIN: blank_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  // item payload and arithmetic registers
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_fire && !ignore) begin
      d_q      <= pix_d;
      addr_q   <= in_col_q;
      sel_q    <= sel_d;
      emit_r_q <= RIX_W'(r32);
      emit_c_q <= COL_W'(c32);
      fend_q   <= (r32 == h32 - 32'd1) && (c32 == w32 - 32'd1);
    end
    if (state_q == ST_MUL) begin
      p_q    <= dms3_pkg::NUM_W'(sum_b) * dms3_pkg::NUM_W'(sum_s);
      aa_q   <= 40'(sum_a) * 40'(sum_a);
      den_q  <= dms3_pkg::DEN_W'({10'(sum_s) * 10'(sum_s), 8'd0});
      mean_q <= '0;
      var_q  <= '0;
    end
    if ((state_q == ST_DM) && div_done) begin
      mean_q <= div_quo[dms3_pkg::MEAN_W-1:0];
    end
    if ((state_q == ST_DV) && div_done) begin
      var_q <= (|div_quo[dms3_pkg::NUM_W-1:dms3_pkg::VAR_W]) ? '1 :
               div_quo[dms3_pkg::VAR_W-1:0];
    end
    if ((state_q == ST_OUT) && (!out_valid_q || out_ch_o.ready)) begin
      out_mean_q <= mean_q;
      out_var_q  <= var_q;
      out_row_q  <= dms3_pkg::POS_W'(emit_r_q);
      out_col_q  <= dms3_pkg::POS_W'(emit_c_q);
      out_fend_q <= fend_q;
    end
  end

  assign out_ch_o.valid          = out_valid_q;
  assign out_ch_o.mean_depth     = out_mean_q;
  assign out_ch_o.depth_variance = out_var_q;
  assign out_ch_o.pixel_row      = out_row_q;
  assign out_ch_o.pixel_col      = out_col_q;
  assign out_ch_o.frame_end      = out_fend_q;

  // checks
  a_acc_done_in_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done |-> (state_q == ST_ACC))
    else $error("window sums finished outside the accumulate pass");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == ST_DM) || (state_q == ST_DV)))
    else $error("divider finished with no division pending");

  a_mem_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_rd_en && mem_wr_en))
    else $error("line store read and write in the same cycle");

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(in_col_q) < w32)
    else $error("input column beyond the row width");

endmodule
